[hdl/softmax_regression_sgd_trainer_defines.svh]
// Assertion macros for the softmax regression trainer.
`ifndef SOFTMAX_REGRESSION_SGD_TRAINER_DEFINES_SVH
`define SOFTMAX_REGRESSION_SGD_TRAINER_DEFINES_SVH
`ifndef SYNTHESIS
`define SMR_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("smr assertion failed");
`define SMR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smr assertion failed");
`else
`define SMR_ASSERT(name, prop)
`define SMR_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[hdl/smr_pkg.sv]
// Shared types, constants and functions of the softmax regression trainer.
package smr_pkg;

    localparam int MAX_FEATURES_DEF = 64;
    localparam int MAX_CLASSES_DEF  = 16;

    localparam int CFG_W   = 17;
    localparam int DATA_W  = 32;
    localparam int DIV_NW  = 48;
    localparam int DIV_DW  = 36;

    localparam logic [16:0] LEARN_RATE_RST    = 17'd6554;
    localparam logic [8:0]  BATCH_SIZE_RST    = 9'd100;
    localparam logic [6:0]  FEATURE_COUNT_RST = 7'd64;
    localparam logic [4:0]  CLASS_COUNT_RST   = 5'd10;

    // log2(e) in Q16.16.
    localparam logic signed [31:0] LOG2E_Q16 = 32'sd94548;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_SAMPLE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_LEARN_RATE    = 2'd0,
        REG_BATCH_SIZE    = 2'd1,
        REG_FEATURE_COUNT = 2'd2,
        REG_CLASS_COUNT   = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_ISSUE,
        S_RD_OUT,
        S_LG_RD,
        S_LG_MUL,
        S_LG_ACC,
        S_EX_MUL,
        S_EX_FRAC,
        S_EX_SHIFT,
        S_PR_START,
        S_PR_WAIT,
        S_GR_RD,
        S_GR_MUL,
        S_GR_WR,
        S_PR_NEXT,
        S_UP_RD,
        S_UP_MUL,
        S_UP_DIV,
        S_UP_WAIT,
        S_UP_WR
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // 2^(i/16) in Q16 for i = 0..16.
    function automatic logic [17:0] pow2_lut(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            5'd16:   v = 18'd131072;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[hdl/softmax_regression_sgd_trainer.sv]
// A write is taken in S_IDLE; a read passes S_RD_ISSUE and S_RD_OUT to read_value; a
// feature walks S_LG_RD, S_LG_MUL, S_LG_ACC per class. A last feature adds exp, a divide
// per class in use and a read, multiply and write per gradient word. A batch end walks
// the whole theta store, with a divide on the shared 48-bit divider per word in use. One
// item is worked at a time. Reset clears control state and the logit ring, then a
// clearing pass zeroes MAX_FEATURES*MAX_CLASSES gradient words before items are taken.
`include "softmax_regression_sgd_trainer_defines.svh"
module softmax_regression_sgd_trainer
    import smr_pkg::*;
#(
    parameter int MAX_FEATURES = MAX_FEATURES_DEF,
    parameter int MAX_CLASSES  = MAX_CLASSES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [5:0]         row,
    input  logic [3:0]         col,
    input  logic signed [31:0] value,
    input  logic [3:0]         label,
    input  logic               end_of_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] read_value,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int DEPTH = MAX_FEATURES * MAX_CLASSES;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(MAX_FEATURES);
    localparam int CW    = $clog2(MAX_CLASSES);
    localparam int NFW   = $clog2(MAX_FEATURES + 1);
    localparam int NCW   = $clog2(MAX_CLASSES + 1);

    state_t state_reg, state_next;

    logic [16:0] lr_reg;
    logic [8:0]  bs_reg;
    logic [6:0]  fc_reg;
    logic [4:0]  cc_reg;

    logic [FW-1:0]      fpos_reg;
    logic [8:0]         samples_reg;
    logic [31:0]        x_reg;
    logic [3:0]         label_reg;
    logic               last_reg;
    logic [AW-1:0]      addr_reg;
    logic               inside_reg;
    logic [CW-1:0]      cls_reg;
    logic [FW-1:0]      row_reg;
    logic [AW-1:0]      ix_reg;
    logic signed [63:0] prod_reg;
    logic signed [17:0] n_reg;
    logic [17:0]        base_reg;
    logic [24:0]        interp_reg;
    logic [35:0]        sum_reg;
    logic signed [17:0] err_reg;
    logic [31:0]        hold_reg;
    logic               inrange_reg;
    logic               neg_reg;
    logic [33:0]        q_reg;
    logic               out_valid_reg;
    logic [31:0]        read_value_reg;

    logic [NFW-1:0] nf;
    logic [NCW-1:0] nc;
    logic [8:0]     bs_eff;
    logic [9:0]     samples_inc;

    logic [AW-1:0] in_addr;
    logic          in_inside;
    logic          in_fire;
    logic [AW-1:0] feat_addr;
    logic [AW-1:0] walk_addr;
    logic          cls_used;
    logic          cls_last;
    logic          out_free;

    logic            t_we;
    logic [AW-1:0]   t_waddr;
    logic [31:0]     t_wdata;
    logic [AW-1:0]   t_raddr;
    logic [31:0]     t_rdata;
    logic            g_we;
    logic [AW-1:0]   g_waddr;
    logic [31:0]     g_wdata;
    logic [AW-1:0]   g_raddr;
    logic [31:0]     g_rdata;
    logic            s_we;
    logic [FW-1:0]   s_waddr;
    logic [FW-1:0]   s_raddr;
    logic [31:0]     s_rdata;

    logic        ring_shift;
    logic [31:0] head_new;
    logic [31:0] cell_q [MAX_CLASSES];
    logic [31:0] head;

    logic              div_start;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic [DIV_NW-1:0] div_quot;
    div_stat_t         div_stat;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;

    logic signed [63:0] head_ext;
    logic signed [63:0] prod_shr;
    logic [31:0]        lg_sum;
    logic [17:0]        ex_m;
    logic [32:0]        ex_left;
    logic [4:0]         ex_rsh;
    logic [31:0]        ex_val;
    logic [31:0]        ex_used;
    logic [3:0]         ex_i;
    logic [17:0]        ex_diff;
    logic [31:0]        gr_new;
    logic [63:0]        up_mag;
    logic signed [63:0] up_delta;
    logic [31:0]        up_new;
    logic signed [17:0] onehot;

    // Effective counts.
    always_comb
    begin
        if (fc_reg == '0)
            nf = NFW'(1);
        else if (32'(fc_reg) > MAX_FEATURES)
            nf = NFW'(MAX_FEATURES);
        else
            nf = NFW'(fc_reg);
        if (cc_reg == '0)
            nc = NCW'(1);
        else if (32'(cc_reg) > MAX_CLASSES)
            nc = NCW'(MAX_CLASSES);
        else
            nc = NCW'(cc_reg);
        bs_eff = (bs_reg == '0) ? 9'd1 : bs_reg;
    end

    assign samples_inc = {1'b0, samples_reg} + 10'd1;
    assign in_inside   = (32'(row) < MAX_FEATURES) && (32'(col) < MAX_CLASSES);
    assign in_addr     = AW'(32'(row) * MAX_CLASSES + 32'(col));
    assign feat_addr   = AW'(32'(fpos_reg) * MAX_CLASSES + 32'(cls_reg));
    assign walk_addr   = AW'(32'(row_reg) * MAX_CLASSES + 32'(cls_reg));
    assign cls_used    = 32'(cls_reg) < 32'(nc);
    assign cls_last    = cls_reg == CW'(MAX_CLASSES - 1);
    assign in_fire     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign onehot      = (32'(cls_reg) == 32'(label_reg)) ? 18'sd65536 : 18'sd0;

    // Memories.
    smr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_theta (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    smr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_grad (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );

    smr_ram #(.WIDTH(32), .DEPTH(MAX_FEATURES)) u_sbuf (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(x_reg),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    // Logit ring: class cls_reg sits in cell 0 and the ring turns once per class.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_CLASSES; gi++)
        begin : g_ring
            logic [31:0] din;
            if (gi == MAX_CLASSES - 1)
            begin : g_tail
                assign din = head_new;
            end
            else
            begin : g_mid
                assign din = cell_q[gi + 1];
            end
            smr_cell #(.WIDTH(32)) u_cell (
                .clk(clk), .rst_n(rst_n), .shift(ring_shift),
                .din(din), .dout(cell_q[gi])
            );
        end
    endgenerate

    assign head = cell_q[0];

    smr_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .quot(div_quot), .stat(div_stat)
    );

    // Shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_LG_MUL:
            begin
                mul_a = x_reg;
                mul_b = t_rdata;
            end
            S_EX_MUL:
            begin
                mul_a = head;
                mul_b = LOG2E_Q16;
            end
            S_GR_MUL:
            begin
                mul_a = s_rdata;
                mul_b = {{14{err_reg[17]}}, err_reg};
            end
            S_UP_MUL:
            begin
                mul_a = g_rdata;
                mul_b = {15'd0, lr_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Datapath arithmetic.
    assign head_ext = {{32{head[31]}}, head};
    assign prod_shr = prod_reg >>> 16;
    assign lg_sum   = sat32(head_ext + prod_shr);
    assign ex_i     = prod_shr[15:12];
    assign ex_diff  = pow2_lut({1'b0, ex_i} + 5'd1) - pow2_lut({1'b0, ex_i});
    assign ex_m     = base_reg + 18'(interp_reg >> 12);
    assign ex_left  = {15'd0, ex_m} << n_reg[3:0];
    assign ex_rsh   = 5'(-n_reg);

    always_comb
    begin
        if (n_reg >= 18'sd16)
            ex_val = 32'hFFFF_FFFF;
        else if (n_reg >= 18'sd0)
            ex_val = ex_left[32] ? 32'hFFFF_FFFF : ex_left[31:0];
        else if (n_reg < -18'sd20)
            ex_val = '0;
        else
            ex_val = 32'(ex_m >> ex_rsh);
        ex_used = cls_used ? ex_val : 32'd0;
    end

    assign gr_new   = sat32({{32{hold_reg[31]}}, hold_reg} + prod_shr);
    assign up_mag   = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
    assign up_delta = neg_reg ? -$signed({30'd0, q_reg}) : $signed({30'd0, q_reg});
    assign up_new   = sat32({{32{hold_reg[31]}}, hold_reg} - up_delta);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // Next state and memory and ring controls.
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        t_we       = 1'b0;
        t_waddr    = walk_addr;
        t_wdata    = up_new;
        t_raddr    = addr_reg;
        g_we       = 1'b0;
        g_waddr    = walk_addr;
        g_wdata    = gr_new;
        g_raddr    = walk_addr;
        s_we       = 1'b0;
        s_waddr    = fpos_reg;
        s_raddr    = row_reg;
        ring_shift = 1'b0;
        head_new   = head;
        div_start  = 1'b0;
        div_num    = {head, 16'd0};
        div_den    = sum_reg;
        case (state_reg)
            S_CLEAR:
            begin
                g_we    = 1'b1;
                g_waddr = ix_reg;
                g_wdata = '0;
                if (ix_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                t_waddr  = in_addr;
                t_wdata  = value;
                if (in_valid)
                begin
                    case (func_t'(func))
                        FUNC_WRITE:  t_we = in_inside;
                        FUNC_READ:   state_next = S_RD_ISSUE;
                        FUNC_SAMPLE: state_next = S_LG_RD;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_RD_ISSUE:
            begin
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_LG_RD:
            begin
                // The sample word is written here, after x_reg took it.
                s_we       = (cls_reg == '0);
                t_raddr    = feat_addr;
                state_next = S_LG_MUL;
            end
            S_LG_MUL:
            begin
                state_next = S_LG_ACC;
            end
            S_LG_ACC:
            begin
                ring_shift = 1'b1;
                head_new   = cls_used ? lg_sum : head;
                if (!cls_last)
                    state_next = S_LG_RD;
                else if ((32'(fpos_reg) + 1) >= 32'(nf))
                    state_next = S_EX_MUL;
                else
                    state_next = S_IDLE;
            end
            S_EX_MUL:
            begin
                state_next = S_EX_FRAC;
            end
            S_EX_FRAC:
            begin
                state_next = S_EX_SHIFT;
            end
            S_EX_SHIFT:
            begin
                ring_shift = 1'b1;
                head_new   = ex_used;
                state_next = cls_last ? S_PR_START : S_EX_MUL;
            end
            S_PR_START:
            begin
                if (!cls_used)
                    state_next = S_PR_NEXT;
                else if (sum_reg == '0)
                    state_next = S_GR_RD;
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_PR_WAIT;
                end
            end
            S_PR_WAIT:
            begin
                if (div_stat.done)
                    state_next = S_GR_RD;
            end
            S_GR_RD:
            begin
                state_next = S_GR_MUL;
            end
            S_GR_MUL:
            begin
                state_next = S_GR_WR;
            end
            S_GR_WR:
            begin
                g_we = 1'b1;
                if ((32'(row_reg) + 1) >= 32'(nf))
                    state_next = S_PR_NEXT;
                else
                    state_next = S_GR_RD;
            end
            S_PR_NEXT:
            begin
                // Logits of the sample are spent, so zeros go back into the ring.
                ring_shift = 1'b1;
                head_new   = '0;
                if (!cls_last)
                    state_next = S_PR_START;
                else if ((samples_inc >= {1'b0, bs_eff}) || last_reg)
                    state_next = S_UP_RD;
                else
                    state_next = S_IDLE;
            end
            S_UP_RD:
            begin
                t_raddr    = ix_reg;
                g_raddr    = ix_reg;
                state_next = S_UP_MUL;
            end
            S_UP_MUL:
            begin
                state_next = (cls_used && (32'(row_reg) < 32'(nf))) ? S_UP_DIV : S_UP_WR;
            end
            S_UP_DIV:
            begin
                div_start  = 1'b1;
                div_num    = up_mag[63:16];
                div_den    = DIV_DW'(samples_reg);
                state_next = S_UP_WAIT;
            end
            S_UP_WAIT:
            begin
                if (div_stat.done)
                    state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                t_we    = inrange_reg;
                t_waddr = ix_reg;
                g_we    = 1'b1;
                g_waddr = ix_reg;
                g_wdata = '0;
                state_next = (ix_reg == AW'(DEPTH - 1)) ? S_IDLE : S_UP_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg        <= LEARN_RATE_RST;
            bs_reg        <= BATCH_SIZE_RST;
            fc_reg        <= FEATURE_COUNT_RST;
            cc_reg        <= CLASS_COUNT_RST;
            fpos_reg      <= '0;
            samples_reg   <= '0;
            cls_reg       <= '0;
            row_reg       <= '0;
            ix_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_LEARN_RATE:    lr_reg <= cfg_data[16:0];
                    REG_BATCH_SIZE:    bs_reg <= cfg_data[8:0];
                    REG_FEATURE_COUNT: fc_reg <= cfg_data[6:0];
                    REG_CLASS_COUNT:   cc_reg <= cfg_data[4:0];
                    default:           lr_reg <= lr_reg;
                endcase
            end

            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if ((state_reg == S_RD_OUT) && out_free)
                out_valid_reg <= 1'b1;

            case (state_reg)
                S_CLEAR:
                begin
                    ix_reg <= (ix_reg == AW'(DEPTH - 1)) ? '0 : ix_reg + 1'b1;
                end
                S_LG_ACC:
                begin
                    cls_reg <= cls_last ? '0 : cls_reg + 1'b1;
                    if (cls_last && ((32'(fpos_reg) + 1) < 32'(nf)))
                        fpos_reg <= fpos_reg + 1'b1;
                end
                S_EX_SHIFT:
                begin
                    cls_reg <= cls_last ? '0 : cls_reg + 1'b1;
                end
                S_PR_START:
                begin
                    row_reg <= '0;
                end
                S_GR_WR:
                begin
                    row_reg <= row_reg + 1'b1;
                end
                S_PR_NEXT:
                begin
                    cls_reg <= cls_last ? '0 : cls_reg + 1'b1;
                    if (cls_last)
                    begin
                        fpos_reg    <= '0;
                        samples_reg <= samples_inc[8:0];
                        row_reg     <= '0;
                        ix_reg      <= '0;
                    end
                end
                S_UP_WR:
                begin
                    if (ix_reg == AW'(DEPTH - 1))
                    begin
                        ix_reg      <= '0;
                        cls_reg     <= '0;
                        row_reg     <= '0;
                        samples_reg <= '0;
                    end
                    else
                    begin
                        ix_reg  <= ix_reg + 1'b1;
                        cls_reg <= cls_last ? '0 : cls_reg + 1'b1;
                        if (cls_last)
                            row_reg <= row_reg + 1'b1;
                    end
                end
                default:
                begin
                    ix_reg <= ix_reg;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg      <= value;
            label_reg  <= label;
            last_reg   <= end_of_data;
            addr_reg   <= in_addr;
            inside_reg <= in_inside;
        end
        if ((state_reg == S_RD_OUT) && out_free)
            read_value_reg <= inside_reg ? t_rdata : 32'd0;
        case (state_reg)
            S_LG_MUL, S_EX_MUL, S_GR_MUL:
            begin
                prod_reg <= mul_p;
                sum_reg  <= (state_reg == S_EX_MUL && cls_reg == '0) ? '0 : sum_reg;
                hold_reg <= g_rdata;
            end
            S_EX_FRAC:
            begin
                n_reg      <= prod_shr[33:16];
                base_reg   <= pow2_lut({1'b0, ex_i});
                interp_reg <= ex_diff[12:0] * prod_shr[11:0];
            end
            S_EX_SHIFT:
            begin
                sum_reg <= sum_reg + 36'(ex_used);
            end
            S_PR_START:
            begin
                err_reg <= 18'sd0 - onehot;
            end
            S_PR_WAIT:
            begin
                err_reg <= $signed({1'b0, div_quot[16:0]}) - onehot;
            end
            S_UP_MUL:
            begin
                prod_reg    <= mul_p;
                hold_reg    <= t_rdata;
                inrange_reg <= cls_used && (32'(row_reg) < 32'(nf));
            end
            S_UP_DIV:
            begin
                neg_reg <= prod_reg[63];
            end
            S_UP_WAIT:
            begin
                q_reg <= div_quot[33:0];
            end
            default:
            begin
                hold_reg <= hold_reg;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;

    `SMR_ASSERT(a_div_start_idle, div_start |-> !div_stat.busy)
    `SMR_ASSERT(a_ring_home, (state_reg == S_IDLE) |-> (cls_reg == '0))
    `SMR_ASSERT_NEXT(a_out_load, (state_reg == S_RD_OUT) && !out_valid_reg, out_valid_reg)
    `SMR_ASSERT(a_theta_write, t_we |-> ((state_reg == S_IDLE) || (state_reg == S_UP_WR)))

endmodule

[hdl/smr_ram.sv]
// Generic single write port RAM with a registered read port.
module smr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/smr_cell.sv]
// One class cell of the rotating logit ring.
module smr_cell #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (shift)
        begin
            value_reg <= din;
        end
    end

    assign dout = value_reg;

endmodule

[hdl/smr_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module smr_div
    import smr_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quot,
    output div_stat_t     stat
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [NW-1:0]    num_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW:0]      trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            num_reg <= num;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DW'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DW-1:0];
            end
            num_reg <= {num_reg[NW-2:0], fits};
        end
    end

    assign quot      = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
